// File: design/rpn_pkg.sv
`timescale 1ns / 1ps

package rpn_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned ITER_W = 5;

  localparam logic [7:0] ASCII_ZERO  = 8'd48;
  localparam logic [7:0] ASCII_NINE  = 8'd57;
  localparam logic [7:0] ASCII_PLUS  = 8'd43;
  localparam logic [7:0] ASCII_MINUS = 8'd45;
  localparam logic [7:0] ASCII_STAR  = 8'd42;
  localparam logic [7:0] ASCII_SLASH = 8'd47;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV
  } alu_op_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_DIVZERO   = 3'd1,
    ST_UNDERFLOW = 3'd2,
    ST_OVERFLOW  = 3'd3,
    ST_COUNT     = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_START,
    S_WAIT,
    S_EMIT
  } state_e;

  typedef struct packed {
    logic    start;
    alu_op_e op;
  } alu_req_t;

  typedef struct packed {
    logic              done;
    logic [WORD_W-1:0] result;
  } alu_rsp_t;

endpackage

// File: design/rpn_stack.sv
`timescale 1ns / 1ps

module rpn_stack #(
  parameter int unsigned DEPTH  = 32,
  parameter int unsigned ADDR_W = 5
) (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [ADDR_W-1:0]         waddr_i,
  input  logic [rpn_pkg::WORD_W-1:0] wdata_i,
  input  logic [ADDR_W-1:0]         raddr_a_i,
  input  logic [ADDR_W-1:0]         raddr_b_i,
  output logic [rpn_pkg::WORD_W-1:0] rdata_a_o,
  output logic [rpn_pkg::WORD_W-1:0] rdata_b_o
);
  import rpn_pkg::*;

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rdata_a_q;
  logic [WORD_W-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem[raddr_a_i];
    rdata_b_q <= mem[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

// File: design/rpn_alu.sv
`timescale 1ns / 1ps

module rpn_alu (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  rpn_pkg::alu_req_t         req_i,
  input  logic [rpn_pkg::WORD_W-1:0] lhs_i,
  input  logic [rpn_pkg::WORD_W-1:0] rhs_i,
  output rpn_pkg::alu_rsp_t         rsp_o
);
  import rpn_pkg::*;

  logic              busy_q, busy_d;
  logic              fin_q, fin_d;
  logic              done_q, done_d;
  logic [ITER_W-1:0] cnt_q, cnt_d;
  alu_op_e           op_q, op_d;
  logic              carry_q, carry_d;
  logic              neg_q, neg_d;
  logic [WORD_W-1:0] a_q, a_d;
  logic [WORD_W-1:0] b_q, b_d;
  logic [WORD_W-1:0] acc_q, acc_d;
  logic [WORD_W-1:0] rem_q, rem_d;
  logic [WORD_W-1:0] result_q, result_d;

  always_comb begin
    logic              bb;
    logic              sum;
    logic [WORD_W:0]   trial;
    busy_d   = busy_q;
    fin_d    = 1'b0;
    done_d   = fin_q;
    cnt_d    = cnt_q;
    op_d     = op_q;
    carry_d  = carry_q;
    neg_d    = neg_q;
    a_d      = a_q;
    b_d      = b_q;
    acc_d    = acc_q;
    rem_d    = rem_q;
    result_d = result_q;
    bb       = 1'b0;
    sum      = 1'b0;
    trial    = '0;

    if (req_i.start) begin
      op_d    = req_i.op;
      cnt_d   = '0;
      busy_d  = 1'b1;
      acc_d   = '0;
      rem_d   = '0;
      carry_d = (req_i.op == OP_SUB);
      neg_d   = lhs_i[WORD_W-1] ^ rhs_i[WORD_W-1];
      if (req_i.op == OP_DIV) begin
        // work on magnitudes, fix the sign at the end
        a_d = lhs_i[WORD_W-1] ? (WORD_W'(0) - lhs_i) : lhs_i;
        b_d = rhs_i[WORD_W-1] ? (WORD_W'(0) - rhs_i) : rhs_i;
      end else begin
        a_d = lhs_i;
        b_d = rhs_i;
      end
    end else if (busy_q) begin
      case (op_q)
        OP_ADD, OP_SUB: begin
          // one full adder, operands shift out LSB first
          bb      = b_q[0] ^ (op_q == OP_SUB);
          sum     = a_q[0] ^ bb ^ carry_q;
          carry_d = (a_q[0] & bb) | (a_q[0] & carry_q) | (bb & carry_q);
          acc_d   = {sum, acc_q[WORD_W-1:1]};
          a_d     = {1'b0, a_q[WORD_W-1:1]};
          b_d     = {1'b0, b_q[WORD_W-1:1]};
        end
        OP_MUL: begin
          acc_d = acc_q + (b_q[0] ? a_q : '0);
          a_d   = {a_q[WORD_W-2:0], 1'b0};
          b_d   = {1'b0, b_q[WORD_W-1:1]};
        end
        OP_DIV: begin
          // restoring step: quotient bits shift into a_q
          trial = {rem_q, a_q[WORD_W-1]} - {1'b0, b_q};
          if (!trial[WORD_W]) begin
            rem_d = trial[WORD_W-1:0];
            a_d   = {a_q[WORD_W-2:0], 1'b1};
          end else begin
            rem_d = {rem_q[WORD_W-2:0], a_q[WORD_W-1]};
            a_d   = {a_q[WORD_W-2:0], 1'b0};
          end
        end
        default: begin
          acc_d = acc_q;
        end
      endcase
      cnt_d = cnt_q + ITER_W'(1);
      if (cnt_q == '1) begin
        busy_d = 1'b0;
        fin_d  = 1'b1;
      end
    end

    if (fin_q) begin
      if (op_q == OP_DIV) begin
        result_d = neg_q ? (WORD_W'(0) - a_q) : a_q;
      end else begin
        result_d = acc_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      op_q   <= OP_ADD;
    end else begin
      busy_q <= busy_d;
      fin_q  <= fin_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
      op_q   <= op_d;
    end
  end

  always_ff @(posedge clk_i) begin
    carry_q  <= carry_d;
    neg_q    <= neg_d;
    a_q      <= a_d;
    b_q      <= b_d;
    acc_q    <= acc_d;
    rem_q    <= rem_d;
    result_q <= result_d;
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.result = result_q;

endmodule

// File: design/postfix_expression_evaluator_top.sv
`timescale 1ns / 1ps

// Channel   Dir  Handshake            Payload
// s_*       in   s_tvalid/s_tready    tdata[7:0] symbol, tlast expr_end
// m_*       out  m_tvalid/m_tready    tdata[31:0] value, tuser[2:0] status
//
// A digit or an ignored character is taken in the idle state. An operator
// passes through a stack read, a launch, 32 bit-serial ALU iterations,
// a finishing step and the write back; a division by zero stops at launch.
// An end-of-expression beat adds a state that loads the output register.
// Reset clears the stack count, the error code and all control state.
// A stalled output beat holds; new symbols are taken once it is loaded.

module postfix_expression_evaluator_top #(
  parameter int unsigned STACK_DEPTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [7:0]  s_tdata_i,   // [7:0] symbol
  input  logic        s_tlast_i,   // expr_end
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output logic [31:0] m_tdata_o,   // [31:0] value
  output logic [2:0]  m_tuser_o    // [2:0] status
);
  import rpn_pkg::*;

  localparam int unsigned ADDR_W = $clog2(STACK_DEPTH);
  localparam int unsigned CNT_W  = $clog2(STACK_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(STACK_DEPTH);

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   count_q, count_d;
  status_e            err_q, err_d;
  alu_op_e            op_q, op_d;
  logic               last_q, last_d;
  logic [WORD_W-1:0]  bottom_q, bottom_d;
  logic               out_valid_q, out_valid_d;
  logic [WORD_W-1:0]  out_value_q, out_value_d;
  status_e            out_status_q, out_status_d;

  logic               accept;
  logic               sym_digit;
  logic               sym_op;
  alu_op_e            sym_opcode;
  logic               ok;
  logic               digit_push;
  logic               digit_ovf;
  logic               op_go;
  logic               op_unf;
  logic               div_zero;
  logic               out_free;

  logic [CNT_W-1:0]   cnt_m1;
  logic [CNT_W-1:0]   cnt_m2;
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr;
  logic [WORD_W-1:0]  mem_wdata;
  logic [WORD_W-1:0]  rhs_rd;
  logic [WORD_W-1:0]  lhs_rd;
  logic [7:0]         digit_val;

  alu_req_t           alu_req;
  alu_rsp_t           alu_rsp;

  assign s_tready_o = (state_q == S_IDLE);
  assign accept     = s_tvalid_i && s_tready_o;
  assign sym_digit  = s_tdata_i inside {[ASCII_ZERO:ASCII_NINE]};
  assign digit_val  = s_tdata_i - ASCII_ZERO;

  always_comb begin
    sym_op     = 1'b1;
    sym_opcode = OP_ADD;
    case (s_tdata_i)
      ASCII_PLUS:  sym_opcode = OP_ADD;
      ASCII_MINUS: sym_opcode = OP_SUB;
      ASCII_STAR:  sym_opcode = OP_MUL;
      ASCII_SLASH: sym_opcode = OP_DIV;
      default:     sym_op     = 1'b0;
    endcase
  end

  assign ok         = (err_q == ST_OK);
  assign digit_push = accept && ok && sym_digit && (count_q < DEPTH_C);
  assign digit_ovf  = accept && ok && sym_digit && (count_q >= DEPTH_C);
  assign op_go      = accept && ok && sym_op && (count_q >= CNT_W'(2));
  assign op_unf     = accept && ok && sym_op && (count_q < CNT_W'(2));
  assign div_zero   = (op_q == OP_DIV) && (rhs_rd == '0);
  assign out_free   = !out_valid_q || m_tready_i;

  assign cnt_m1 = count_q - CNT_W'(1);
  assign cnt_m2 = count_q - CNT_W'(2);

  rpn_stack #(
    .DEPTH  (STACK_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_stack (
    .clk_i     (clk_i),
    .we_i      (mem_we),
    .waddr_i   (mem_waddr),
    .wdata_i   (mem_wdata),
    .raddr_a_i (cnt_m1[ADDR_W-1:0]),
    .raddr_b_i (cnt_m2[ADDR_W-1:0]),
    .rdata_a_o (rhs_rd),
    .rdata_b_o (lhs_rd)
  );

  rpn_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .lhs_i  (lhs_rd),
    .rhs_i  (rhs_rd),
    .rsp_o  (alu_rsp)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (op_go) begin
            state_d = S_READ;
          end else if (s_tlast_i) begin
            state_d = S_EMIT;
          end
        end
      end
      S_READ: state_d = S_START;
      S_START: begin
        if (div_zero) begin
          state_d = last_q ? S_EMIT : S_IDLE;
        end else begin
          state_d = S_WAIT;
        end
      end
      S_WAIT: begin
        if (alu_rsp.done) begin
          state_d = last_q ? S_EMIT : S_IDLE;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    count_d       = count_q;
    err_d         = err_q;
    op_d          = op_q;
    last_d        = last_q;
    bottom_d      = bottom_q;
    mem_we        = 1'b0;
    mem_waddr     = count_q[ADDR_W-1:0];
    mem_wdata     = {{(WORD_W-8){1'b0}}, digit_val};
    alu_req.start = 1'b0;
    alu_req.op    = op_q;
    out_valid_d   = out_valid_q && !m_tready_i;
    out_value_d   = out_value_q;
    out_status_d  = out_status_q;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_d   = sym_opcode;
          last_d = s_tlast_i;
          if (digit_push) begin
            mem_we  = 1'b1;
            count_d = count_q + CNT_W'(1);
            if (count_q == '0) begin
              bottom_d = mem_wdata;
            end
          end
          if (digit_ovf) begin
            err_d = ST_OVERFLOW;
          end
          if (op_unf) begin
            err_d = ST_UNDERFLOW;
          end
        end
      end
      S_START: begin
        if (div_zero) begin
          err_d = ST_DIVZERO;
        end else begin
          alu_req.start = 1'b1;
        end
      end
      S_WAIT: begin
        if (alu_rsp.done) begin
          // drop the right operand, overwrite the left one
          mem_we    = 1'b1;
          mem_waddr = cnt_m2[ADDR_W-1:0];
          mem_wdata = alu_rsp.result;
          count_d   = cnt_m1;
          if (count_q == CNT_W'(2)) begin
            bottom_d = alu_rsp.result;
          end
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_value_d = '0;
          if (err_q != ST_OK) begin
            out_status_d = err_q;
          end else if (count_q != CNT_W'(1)) begin
            out_status_d = ST_COUNT;
          end else begin
            out_status_d = ST_OK;
            out_value_d  = bottom_q;
          end
          count_d = '0;
          err_d   = ST_OK;
        end
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      err_q       <= ST_OK;
      op_q        <= OP_ADD;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      err_q       <= err_d;
      op_q        <= op_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bottom_q     <= bottom_d;
    out_value_q  <= out_value_d;
    out_status_q <= out_status_d;
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = out_value_q;
  assign m_tuser_o  = out_status_q;

  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    alu_rsp.done |-> (state_q == S_WAIT))
    else $error("ALU result arrived outside the wait state");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DEPTH_C)
    else $error("stack count beyond depth");

  a_emit_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT && out_free) |=> (count_q == '0 && err_q == ST_OK && m_tvalid_o))
    else $error("expression state not cleared after emit");

  a_ok_has_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT && out_free && err_q == ST_OK && count_q == CNT_W'(1))
      |=> (m_tuser_o == ST_OK))
    else $error("single stack entry not reported as ok");

endmodule

// File: test/postfix_expression_evaluator_top_test.sv
`timescale 1ns / 1ps

module postfix_expression_evaluator_top_test;
  import rpn_pkg::*;

  localparam int unsigned STACK_DEPTH  = 32;
  localparam int unsigned TARGET_ITEMS = 1600;
  localparam logic [7:0]  OPS [4]      = '{ASCII_PLUS, ASCII_MINUS, ASCII_STAR, ASCII_SLASH};

  typedef struct {
    logic [31:0] value;
    status_e     status;
  } expr_result_t;

  typedef enum logic [1:0] {
    RDY_ALWAYS,
    RDY_COIN,
    RDY_SPARSE,
    RDY_WAVE
  } ready_mode_e;

  // Tracks the operand stack and checks the value and status of each expression.
  class expr_scoreboard;
    int           words [STACK_DEPTH];
    int unsigned  depth;
    status_e      err;
    expr_result_t pending [$];
    int unsigned  n_fail;
    int unsigned  n_seen;
    int unsigned  by_status [5];

    function new();
      depth  = 0;
      err    = ST_OK;
      n_fail = 0;
      n_seen = 0;
      foreach (by_status[i]) by_status[i] = 0;
    endfunction

    function void apply_op(logic [7:0] sym);
      int lhs;
      int rhs;
      int res;
      if (depth < 2) begin
        err = ST_UNDERFLOW;
        return;
      end
      rhs = words[depth-1];
      lhs = words[depth-2];
      case (sym)
        ASCII_PLUS:  res = lhs + rhs;
        ASCII_MINUS: res = lhs - rhs;
        ASCII_STAR:  res = lhs * rhs;
        default: begin
          if (rhs == 0) begin
            err = ST_DIVZERO;
            return;
          end
          // most negative over minus one wraps back to itself
          if (lhs == int'(32'h8000_0000) && rhs == -1) begin
            res = lhs;
          end else begin
            res = lhs / rhs;
          end
        end
      endcase
      words[depth-2] = res;
      depth--;
    endfunction

    function void note_symbol(logic [7:0] sym, logic last);
      expr_result_t r;
      if (err == ST_OK) begin
        if (sym >= ASCII_ZERO && sym <= ASCII_NINE) begin
          if (depth >= STACK_DEPTH) begin
            err = ST_OVERFLOW;
          end else begin
            words[depth] = int'(sym - ASCII_ZERO);
            depth++;
          end
        end else if (sym == ASCII_PLUS || sym == ASCII_MINUS ||
                     sym == ASCII_STAR || sym == ASCII_SLASH) begin
          apply_op(sym);
        end
      end
      if (last) begin
        r.value = '0;
        if (err != ST_OK) begin
          r.status = err;
        end else if (depth != 1) begin
          r.status = ST_COUNT;
        end else begin
          r.status = ST_OK;
          r.value  = words[0];
        end
        pending.push_back(r);
        depth = 0;
        err   = ST_OK;
      end
    endfunction

    function void check_result(logic [31:0] value, logic [2:0] status);
      expr_result_t e;
      if (pending.size() == 0) begin
        $display("%0t: result with nothing pending: value=%0d status=%0d",
                 $time, $signed(value), status);
        n_fail++;
        return;
      end
      e = pending.pop_front();
      n_seen++;
      by_status[e.status]++;
      if (value !== e.value) begin
        $display("%0t: value mismatch: expected %0d, actual %0d",
                 $time, $signed(e.value), $signed(value));
        n_fail++;
      end
      if (status !== e.status) begin
        $display("%0t: status mismatch: expected %0d, actual %0d",
                 $time, e.status, status);
        n_fail++;
      end
    endfunction
  endclass

  logic        clk_i      = 1'b0;
  logic        rst_ni     = 1'b0;
  logic        s_tvalid_i = 1'b0;
  logic        s_tready_o;
  logic [7:0]  s_tdata_i  = 8'h00;   // [7:0] symbol
  logic        s_tlast_i  = 1'b0;    // expr_end
  logic        m_tvalid_o;
  logic        m_tready_i = 1'b0;
  logic [31:0] m_tdata_o;            // [31:0] value
  logic [2:0]  m_tuser_o;            // [2:0] status

  expr_scoreboard sb;
  logic [7:0]     expr_q [$];
  int unsigned    burst_left = 0;
  int unsigned    items_sent = 0;
  ready_mode_e    ready_mode = RDY_ALWAYS;
  int unsigned    ready_left = 0;
  logic [7:0]     ready_tick = '0;

  postfix_expression_evaluator_top #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_tvalid_i(s_tvalid_i),
    .s_tready_o(s_tready_o),
    .s_tdata_i (s_tdata_i),
    .s_tlast_i (s_tlast_i),
    .m_tvalid_o(m_tvalid_o),
    .m_tready_i(m_tready_i),
    .m_tdata_o (m_tdata_o),
    .m_tuser_o (m_tuser_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Check before noting, so an early output cannot match the beat of the same edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_tvalid_o && m_tready_i) sb.check_result(m_tdata_o, m_tuser_o);
      if (s_tvalid_i && s_tready_o) sb.note_symbol(s_tdata_i, s_tlast_i);
    end
  end

  always @(negedge clk_i) begin
    if (ready_left == 0) begin
      ready_mode <= ready_mode_e'($urandom_range(0, 3));
      ready_left <= $urandom_range(32, 400);
    end else begin
      ready_left <= ready_left - 1;
    end
    ready_tick <= ready_tick + 1'b1;
    case (ready_mode)
      RDY_ALWAYS: m_tready_i <= 1'b1;
      RDY_COIN:   m_tready_i <= 1'($urandom_range(0, 1));
      RDY_SPARSE: m_tready_i <= ($urandom_range(0, 5) == 0);
      default:    m_tready_i <= ready_tick[3];
    endcase
  end

  function automatic logic is_digit(logic [7:0] c);
    return c >= ASCII_ZERO && c <= ASCII_NINE;
  endfunction

  function automatic logic is_op(logic [7:0] c);
    return c == ASCII_PLUS || c == ASCII_MINUS || c == ASCII_STAR || c == ASCII_SLASH;
  endfunction

  function automatic logic [7:0] rand_digit();
    return ASCII_ZERO + 8'($urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] pick_op(int unsigned mul_pct);
    if ($urandom_range(0, 99) < mul_pct) return ASCII_STAR;
    return OPS[$urandom_range(0, 3)];
  endfunction

  function automatic logic [7:0] noise_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (is_digit(c) || is_op(c));
    return c;
  endfunction

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_beat(input logic [7:0] sym, input logic last);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      case ($urandom_range(0, 7))
        0, 1:    gap = 0;
        2:       gap = $urandom_range(10, 60);
        default: gap = $urandom_range(1, 6);
      endcase
      if (gap != 0) begin
        s_tvalid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    s_tvalid_i <= 1'b1;
    s_tdata_i  <= sym;
    s_tlast_i  <= last;
    do @(posedge clk_i); while (!s_tready_o);
    @(negedge clk_i);
  endtask

  task automatic send_expr();
    foreach (expr_q[i]) begin
      send_beat(expr_q[i], i == expr_q.size() - 1);
      items_sent++;
    end
    expr_q.delete();
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) expr_q.push_back(s[i]);
    send_expr();
  endtask

  // Valid postfix with random operands; the live depth never exceeds max_digits.
  task automatic gen_wellformed(input int unsigned max_digits, input int unsigned mul_pct,
                                input int unsigned noise_pct);
    int unsigned target;
    int unsigned pushed;
    int unsigned live;
    target = $urandom_range(1, max_digits);
    pushed = 0;
    live   = 0;
    while (pushed < target || live > 1) begin
      if (live >= 2 && (pushed >= target || $urandom_range(0, 2) == 0)) begin
        expr_q.push_back(pick_op(mul_pct));
        live--;
      end else begin
        expr_q.push_back(rand_digit());
        pushed++;
        live++;
      end
      if ($urandom_range(0, 99) < noise_pct) expr_q.push_back(noise_char());
    end
  endtask

  task automatic gen_broken();
    int unsigned len;
    len = $urandom_range(1, 40);
    repeat (len) begin
      case ($urandom_range(0, 4))
        0, 1:    expr_q.push_back(rand_digit());
        2, 3:    expr_q.push_back(pick_op(0));
        default: expr_q.push_back(noise_char());
      endcase
    end
  endtask

  task automatic gen_overflow();
    repeat ($urandom_range(STACK_DEPTH + 1, STACK_DEPTH + 6)) expr_q.push_back(rand_digit());
    repeat ($urandom_range(0, 3)) expr_q.push_back(pick_op(0));
  endtask

  // Build 2^31, which wraps to the most negative value, then finish with a wrap case.
  task automatic gen_most_negative();
    expr_q.push_back(ASCII_ZERO + 8'd2);
    repeat (30) begin
      expr_q.push_back(ASCII_ZERO + 8'd2);
      expr_q.push_back(ASCII_STAR);
    end
    case ($urandom_range(0, 3))
      0, 1: begin
        expr_q.push_back(ASCII_ZERO);
        expr_q.push_back(ASCII_ZERO + 8'd1);
        expr_q.push_back(ASCII_MINUS);
        expr_q.push_back(ASCII_SLASH);
      end
      2: begin
        expr_q.push_back(ASCII_ZERO + 8'd1);
        expr_q.push_back(ASCII_MINUS);
      end
      default: begin
        expr_q.push_back(ASCII_ZERO + 8'd2);
        expr_q.push_back(ASCII_STAR);
      end
    endcase
  endtask

  initial begin
    int unsigned pick;
    sb = new();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(negedge clk_i);

    send_text("5");
    send_text("93-");
    send_text("78*");
    send_text("92/");
    send_text("50/");
    send_text("+");
    send_text("9+");
    send_text("12");
    send_text("09-2/");
    expr_q.push_back(8'h00);
    expr_q.push_back(ASCII_ZERO + 8'd7);
    expr_q.push_back(8'hFF);
    send_expr();

    while (items_sent < TARGET_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        gen_wellformed(8, 25, 5);
      end else if (pick < 65) begin
        gen_wellformed(STACK_DEPTH, 25, 3);
      end else if (pick < 73) begin
        gen_wellformed(12, 80, 0);
      end else if (pick < 88) begin
        gen_broken();
      end else if (pick < 92) begin
        gen_overflow();
      end else if (pick < 96) begin
        gen_most_negative();
      end else begin
        expr_q.push_back(noise_char());
      end
      send_expr();
    end

    s_tvalid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);

    $display("Sent %0d input characters; checked %0d expression results.",
             items_sent, sb.n_seen);
    $display("Results by status: ok %0d, div-by-zero %0d, underflow %0d, overflow %0d, count %0d",
             sb.by_status[ST_OK], sb.by_status[ST_DIVZERO], sb.by_status[ST_UNDERFLOW],
             sb.by_status[ST_OVERFLOW], sb.by_status[ST_COUNT]);
    if (sb.n_fail == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timeout: the run did not finish in time");
    $display("*** FAILED ***");
    $finish;
  end

endmodule
